@@ rtl/cleb_pkg.sv @@
`default_nettype none

package cleb_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 1024;

   localparam logic [7:0] KEY_LEFT  = 8'h3C;
   localparam logic [7:0] KEY_RIGHT = 8'h3E;
   localparam logic [7:0] KEY_BACK  = 8'h2D;

   localparam logic [1:0] CMD_KEY   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_EDGE = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_HOLD  = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      OP_MOVE_LEFT  = 2'd0,
      OP_MOVE_RIGHT = 2'd1,
      OP_READ       = 2'd2
   } op_type;

   typedef struct packed {
      logic [7:0] character;
      logic       char_valid;
      logic       last_char;
      logic [1:0] status;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/cleb_ram.sv @@
`default_nettype none

module cleb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = cleb_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     we,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[addr] <= wr_data;
      end
      rd_data_ff <= store_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/cursor_line_edit_buffer.sv @@
`default_nettype none

// Keystroke line editor kept in a gap buffer of CAPACITY bytes.
// Request channel (req_*): command 0 edits with key ('<' left, '>' right,
// '-' delete before cursor, any other byte inserts), command 1 returns the
// next line character, command 2 clears the line. Every request transaction
// yields exactly one response transaction on rsp_*, in order.
// Requests that need no memory data (insert, delete, clear, edge and full
// cases, empty read) are answered from the idle state; cursor moves and
// character reads first read the single-port text memory, then in the fetch
// state write the byte back or return it. Responses are registered.
// Throughput: one request every cycle for the first group while the output
// is not stalled; the second group holds req_ready low until its fetch ends.
// One request is in work at a time; a finished response waits in the output
// register while the next request is taken, and one more finished response
// is held inside when the receiver stalls, with req_ready low until it drains.
// Reset (synchronous) empties the line, rewinds reading and drops any pending
// response; memory contents are not cleared.

module cursor_line_edit_buffer #(
   parameter int unsigned CAPACITY = cleb_pkg::CAPACITY_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_key,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_character,
   output logic            rsp_char_valid,
   output logic            rsp_last_char,
   output logic [1:0]      rsp_status
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

   cleb_pkg::state_type  state_ff, state_in;
   cleb_pkg::op_type     op_ff, op_in;
   logic [CW-1:0]        left_ff, left_in;
   logic [CW-1:0]        right_ff, right_in;
   logic [CW-1:0]        rdpos_ff, rdpos_in;
   logic [CW-1:0]        pos_ff, pos_in;
   cleb_pkg::result_type hold_ff, hold_in;
   cleb_pkg::result_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [7:0]    mem_wdata;
   logic [7:0]    mem_rdata;

   logic [CW-1:0] total;
   logic [CW-1:0] left_dec;
   logic [CW-1:0] top_right;
   logic [CW-1:0] top_right_dec;
   logic [CW-1:0] total_dec;
   logic [CW-1:0] read_p;
   logic [CW-1:0] read_idx;
   logic          slot_free;
   logic          res_ready;
   cleb_pkg::result_type result;

   cleb_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_text_ram (
      .clock   (clock),
      .addr    (mem_addr),
      .we      (mem_we),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   assign total         = left_ff + right_ff;
   assign total_dec     = total - CW'(1);
   assign left_dec      = left_ff - CW'(1);
   assign top_right     = CAP_CW - right_ff;
   assign top_right_dec = top_right - CW'(1);
   assign read_p        = (rdpos_ff < total) ? rdpos_ff : '0;
   assign read_idx      = (read_p < left_ff) ? read_p : top_right + (read_p - left_ff);
   assign slot_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == cleb_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rdpos_in     = rdpos_ff;
      pos_in       = pos_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_addr     = '0;
      mem_we       = 1'b0;
      mem_wdata    = req_key;
      result       = '0;
      res_ready    = 1'b0;

      unique case (state_ff)
         cleb_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_command)
                  cleb_pkg::CMD_KEY: begin
                     rdpos_in = '0;
                     priority if (req_key == cleb_pkg::KEY_LEFT) begin
                        if (left_ff == '0) begin
                           result.status = cleb_pkg::STATUS_EDGE;
                           res_ready     = 1'b1;
                        end else begin
                           mem_addr = left_dec[AW-1:0];
                           op_in    = cleb_pkg::OP_MOVE_LEFT;
                           state_in = cleb_pkg::ST_FETCH;
                        end
                     end else if (req_key == cleb_pkg::KEY_RIGHT) begin
                        if (right_ff == '0) begin
                           result.status = cleb_pkg::STATUS_EDGE;
                           res_ready     = 1'b1;
                        end else begin
                           mem_addr = top_right[AW-1:0];
                           op_in    = cleb_pkg::OP_MOVE_RIGHT;
                           state_in = cleb_pkg::ST_FETCH;
                        end
                     end else if (req_key == cleb_pkg::KEY_BACK) begin
                        if (left_ff == '0) begin
                           result.status = cleb_pkg::STATUS_EDGE;
                        end else begin
                           left_in = left_dec;
                        end
                        res_ready = 1'b1;
                     end else begin
                        if (total >= CAP_CW) begin
                           result.status = cleb_pkg::STATUS_FULL;
                        end else begin
                           mem_addr = left_ff[AW-1:0];
                           mem_we   = 1'b1;
                           left_in  = left_ff + CW'(1);
                        end
                        res_ready = 1'b1;
                     end
                  end
                  cleb_pkg::CMD_READ: begin
                     if (total == '0) begin
                        result.last_char = 1'b1;
                        rdpos_in         = '0;
                        res_ready        = 1'b1;
                     end else begin
                        mem_addr = read_idx[AW-1:0];
                        pos_in   = read_p;
                        op_in    = cleb_pkg::OP_READ;
                        state_in = cleb_pkg::ST_FETCH;
                     end
                  end
                  cleb_pkg::CMD_CLEAR: begin
                     left_in   = '0;
                     right_in  = '0;
                     rdpos_in  = '0;
                     res_ready = 1'b1;
                  end
                  default: begin
                     res_ready = 1'b1;
                  end
               endcase
            end
         end
         cleb_pkg::ST_FETCH: begin
            res_ready = 1'b1;
            mem_wdata = mem_rdata;
            unique case (op_ff)
               cleb_pkg::OP_MOVE_LEFT: begin
                  mem_addr = top_right_dec[AW-1:0];
                  mem_we   = 1'b1;
                  left_in  = left_dec;
                  right_in = right_ff + CW'(1);
               end
               cleb_pkg::OP_MOVE_RIGHT: begin
                  mem_addr = left_ff[AW-1:0];
                  mem_we   = 1'b1;
                  left_in  = left_ff + CW'(1);
                  right_in = right_ff - CW'(1);
               end
               cleb_pkg::OP_READ: begin
                  result.character  = mem_rdata;
                  result.char_valid = 1'b1;
                  if (pos_ff == total_dec) begin
                     result.last_char = 1'b1;
                     rdpos_in         = '0;
                  end else begin
                     rdpos_in = pos_ff + CW'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         cleb_pkg::ST_HOLD: begin
            if (slot_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = cleb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cleb_pkg::ST_IDLE;
         end
      endcase

      if (res_ready) begin
         if (slot_free) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
            state_in     = cleb_pkg::ST_IDLE;
         end else begin
            hold_in  = result;
            state_in = cleb_pkg::ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cleb_pkg::ST_IDLE;
         left_ff      <= '0;
         right_ff     <= '0;
         rdpos_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rdpos_ff     <= rdpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      pos_ff  <= pos_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_character  = rsp_ff.character;
   assign rsp_char_valid = rsp_ff.char_valid;
   assign rsp_last_char  = rsp_ff.last_char;
   assign rsp_status     = rsp_ff.status;

endmodule

`default_nettype wire

@@ rtl/cleb_checker.sv @@
`default_nettype none

module cleb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_command,
   input wire logic [7:0] req_key,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_character,
   input wire logic       rsp_char_valid,
   input wire logic       rsp_last_char,
   input wire logic [1:0] rsp_status
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_command) && $stable(req_key))
      else $error("request changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character)
         && $stable(rsp_status) && $stable(rsp_last_char))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response present right after reset");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_character == 8'd0)
      else $error("character nonzero without char_valid");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cleb_pkg::STATUS_DONE |-> !rsp_last_char && !rsp_char_valid)
      else $error("character or last_char set on a rejected key");

endmodule

bind cursor_line_edit_buffer cleb_checker u_cleb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_command    (req_command),
   .req_key        (req_key),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_character  (rsp_character),
   .rsp_char_valid (rsp_char_valid),
   .rsp_last_char  (rsp_last_char),
   .rsp_status     (rsp_status)
);

`default_nettype wire
